// ===== rtl/core/assert_macros.svh =====
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// ===== rtl/core/pafe_pkg.sv =====
package pafe_pkg;
  localparam int unsigned COORD_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF   = 8;
  localparam int unsigned T_BITS          = 16;
  localparam int unsigned T_W             = 17;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam logic [1:0] REG_END_X = 2'd0;
  localparam logic [1:0] REG_END_Y = 2'd1;
  localparam logic [1:0] REG_END_Z = 2'd2;
  localparam logic [1:0] REG_CROSS = 2'd3;
  localparam logic KIND_FIT  = 1'b0;
  localparam logic KIND_EVAL = 1'b1;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } pafe_cmd_t;

  typedef struct packed {
    logic done;
  } pafe_sts_t;
endpackage

// ===== rtl/core/pafe_ctrl.sv =====
module pafe_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output pafe_pkg::pafe_cmd_t cmd,
  input  pafe_pkg::pafe_sts_t sts
);
  import pafe_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WORK = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0] state_r, state_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_WORK;
        end
      end
      ST_WORK: begin
        cmd.step = 1'b1;
        if (sts.done) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end
endmodule

// ===== rtl/core/pafe_dp.sv =====
module pafe_dp #(
  parameter int unsigned COORD_WIDTH = pafe_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pafe_pkg::pafe_cmd_t           cmd,
  output pafe_pkg::pafe_sts_t           sts,
  input  logic                          cfg_we,
  input  logic [pafe_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [COORD_WIDTH-1:0]        cfg_data,
  input  logic                          kind,
  input  logic signed [COORD_WIDTH-1:0] pos_x,
  input  logic signed [COORD_WIDTH-1:0] pos_y,
  input  logic signed [COORD_WIDTH-1:0] pos_z,
  input  logic [pafe_pkg::T_W-1:0]      param_t,
  output logic                          ok,
  output logic signed [COORD_WIDTH-1:0] res_x,
  output logic signed [COORD_WIDTH-1:0] res_y,
  output logic signed [COORD_WIDTH-1:0] res_z
);
  import pafe_pkg::*;

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned DW = CW + 3;         // curvature, apex_pos
  localparam int unsigned MW = 2 * T_W;        // second operand, holds t*t
  localparam int unsigned PW = DW + MW;        // product width
  localparam int unsigned AW = PW + 1;         // accumulator
  localparam int unsigned LW = CW + T_W + 1;   // interpolation product
  localparam int unsigned ZS = 2 * T_BITS;

  logic signed [CW-1:0] end_x_r, end_y_r, end_z_r, cross_r;
  logic signed [CW-1:0] start_x_r, start_y_r;
  logic signed [DW-1:0] apex_pos_r, curv_r;
  logic signed [CW-1:0] apex_h_r;
  logic fit_valid_r;

  logic kind_r;
  logic signed [CW-1:0] px_r, py_r, pz_r;
  logic [T_W-1:0] t_r;
  logic [2:0] ph_r;
  logic signed [DW-1:0] mul_a;
  logic signed [MW-1:0] mul_b;
  logic signed [PW-1:0] prod_r;
  logic signed [AW-1:0] acc_r, acc_nxt;
  logic signed [LW-1:0] lx_r, ly_r;
  logic ok_r;
  logic signed [CW-1:0] rx_r, ry_r, rz_r;

  function automatic logic signed [CW-1:0] sat(input logic signed [AW-1:0] v);
    logic signed [AW-1:0] hi, lo;
    hi = AW'(signed'({1'b0, {(CW-1){1'b1}}}));
    lo = -hi - AW'(1);
    if (v > hi) sat = hi[CW-1:0];
    else if (v < lo) sat = lo[CW-1:0];
    else sat = v[CW-1:0];
  endfunction

  // fit checks
  logic signed [CW+2:0] dg2;
  logic fit_ok;
  assign dg2 = (CW+3)'(end_z_r) - (CW+3)'(pz_r) - ((CW+3)'(cross_r) <<< 1);
  assign fit_ok = !((px_r == end_x_r) && (py_r == end_y_r)) && (cross_r != '0)
                  && (dg2 != '0);

  // one multiplier, phases: 0 x, 1 y, 2 apex_pos*t, 3 t*t, 4 curv*(t*t)
  always_comb begin
    mul_a = '0;
    mul_b = MW'(signed'({1'b0, t_r}));
    unique case (ph_r)
      3'd0: mul_a = DW'(end_x_r) - DW'(start_x_r);
      3'd1: mul_a = DW'(end_y_r) - DW'(start_y_r);
      3'd2: mul_a = apex_pos_r;
      3'd3: mul_a = DW'(signed'({1'b0, t_r}));
      3'd4: begin
        mul_a = curv_r;
        mul_b = prod_r[MW-1:0];
      end
      default: mul_a = '0;
    endcase
  end

  always_comb begin
    acc_nxt = acc_r;
    unique case (ph_r)
      3'd3: acc_nxt = (AW'(apex_h_r) <<< ZS) + (AW'(prod_r) <<< T_BITS);
      3'd4: acc_nxt = acc_r;
      3'd5: acc_nxt = acc_r + AW'(prod_r);
      default: acc_nxt = acc_r;
    endcase
  end

  logic signed [AW-1:0] xs, ys, zs;
  assign xs = ((AW'(start_x_r) <<< T_BITS) + AW'(lx_r) + (AW'(1) <<< (T_BITS-1)))
              >>> T_BITS;
  assign ys = ((AW'(start_y_r) <<< T_BITS) + AW'(ly_r) + (AW'(1) <<< (T_BITS-1)))
              >>> T_BITS;
  assign zs = (acc_r + (AW'(1) <<< (ZS-1))) >>> ZS;
  assign sts.done = (ph_r == 3'd6) || (kind_r == KIND_FIT) || !fit_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      end_x_r <= '0; end_y_r <= '0; end_z_r <= '0; cross_r <= '0;
      start_x_r <= '0; start_y_r <= '0; apex_pos_r <= '0; curv_r <= '0;
      apex_h_r <= '0; fit_valid_r <= 1'b0; ph_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_END_X: end_x_r <= cfg_data;
          REG_END_Y: end_y_r <= cfg_data;
          REG_END_Z: end_z_r <= cfg_data;
          REG_CROSS: cross_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load) begin
        kind_r <= kind;
        px_r <= pos_x; py_r <= pos_y; pz_r <= pos_z;
        t_r <= (param_t > T_W'(1 << T_BITS)) ? T_W'(1 << T_BITS) : param_t;
        ph_r <= '0;
      end else if (cmd.step) begin
        ph_r <= ph_r + 3'd1;
        prod_r <= PW'(mul_a) * PW'(mul_b);
        acc_r <= acc_nxt;
        if (ph_r == 3'd1) lx_r <= prod_r[LW-1:0];
        if (ph_r == 3'd2) ly_r <= prod_r[LW-1:0];
      end
      if (cmd.finish) begin
        ok_r <= 1'b0; rx_r <= '0; ry_r <= '0; rz_r <= '0;
        if (kind_r == KIND_FIT) begin
          ok_r <= fit_ok;
          if (fit_ok) begin
            start_x_r <= px_r; start_y_r <= py_r; apex_h_r <= pz_r;
            curv_r <= -(DW'(cross_r) <<< 2);
            apex_pos_r <= DW'(end_z_r) - DW'(pz_r) + (DW'(cross_r) <<< 2);
            fit_valid_r <= 1'b1;
          end
        end else if (fit_valid_r) begin
          ok_r <= 1'b1;
          rx_r <= sat(xs); ry_r <= sat(ys); rz_r <= sat(zs);
        end
      end
    end
  end

  assign ok = ok_r;
  assign res_x = rx_r;
  assign res_y = ry_r;
  assign res_z = rz_r;
endmodule

// ===== rtl/core/parabolic_arc_fit_and_eval_core.sv =====
// Parabolic arc fit and evaluation. A request of kind 0 sets the start point and
// refits the arc to the configured end point (ok=0 keeps the old fit); kind 1
// returns x, y by linear interpolation and z from the fitted arc, rounded and
// saturated (ok=0 and zeros before any fit). One request at a time: a fit
// result is offered once its request has passed the work state, and an
// evaluate result once one shared multiplier has been stepped through seven
// phases there; the next request is taken only after the result has left.
`include "assert_macros.svh"
module parabolic_arc_fit_and_eval_core #(
  parameter int unsigned COORD_WIDTH = pafe_pkg::COORD_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic in_tuser,                 // kind
  input  logic [((3*COORD_WIDTH+17+7)/8)*8-1:0] in_tdata, // pos_x, pos_y, pos_z, param_t
  output logic out_tvalid,
  input  logic out_tready,
  output logic [((3*COORD_WIDTH+7)/8)*8-1:0] out_tdata, // out_x, out_y, out_z
  output logic out_tuser,                // ok
  input  logic cfg_we,
  input  logic [pafe_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [COORD_WIDTH-1:0] cfg_data
);
  import pafe_pkg::*;
  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned OW = ((3*CW+7)/8)*8;

  pafe_cmd_t cmd;
  pafe_sts_t sts;
  logic signed [CW-1:0] rx, ry, rz;

  pafe_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .out_valid(out_tvalid), .out_ready(out_tready), .cmd(cmd), .sts(sts)
  );

  pafe_dp #(.COORD_WIDTH(CW)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .kind(in_tuser), .pos_x(in_tdata[CW-1:0]), .pos_y(in_tdata[2*CW-1:CW]),
    .pos_z(in_tdata[3*CW-1:2*CW]), .param_t(in_tdata[3*CW+T_W-1:3*CW]),
    .ok(out_tuser), .res_x(rx), .res_y(ry), .res_z(rz)
  );

  assign out_tdata = OW'({rz, ry, rx});

  `ASSERT_NEXT(a_no_in_while_out, clk, rst_n, out_tvalid && !out_tready, !in_tready, "input taken while result pending")
  `ASSERT_IMPL(a_ready_excl, clk, rst_n, !(in_tready && out_tvalid), "ready and result together")
endmodule
